FILE: hdl/plng_pkg.sv
`default_nettype none

package plng_pkg;

	// field and lattice limits
	localparam int IDX_W       = 24;
	localparam int MAX_SIDE    = 256;
	localparam int MAX_DIMS    = 3;
	localparam int DIMS_W      = 2;
	localparam int SIDE_W      = 9;
	localparam int CFG_W       = 9;
	localparam int REG_IDX_W   = 2;
	localparam int AXIS_W      = 2;

	// digit of one coordinate and the divisor that produces it
	localparam int DIG_W       = $clog2(MAX_SIDE);
	localparam int LEFF_W      = DIG_W + 1;

	// divider pipeline: bits retired per stage, stages per coordinate
	localparam int STG_BITS    = 8;
	localparam int STG_PER_DIV = IDX_W / STG_BITS;
	localparam int NSTG        = MAX_DIMS * STG_PER_DIV;

	// powers of the side length and signed neighbour arithmetic
	localparam int POW_W       = IDX_W + 1;
	localparam int ACC_W       = POW_W + 1;
	localparam int POW_IDX_W   = $clog2(MAX_DIMS + 1);

	// result counter and queue
	localparam int CNT_W       = $clog2(2 * MAX_DIMS + 2);
	localparam int QDEPTH      = 4;
	localparam int QPTR_W      = $clog2(QDEPTH);

	typedef enum logic [REG_IDX_W-1:0] {
		REG_NUM_DIMS    = 2'd0,
		REG_SIDE_LENGTH = 2'd1,
		REG_TRIANGULAR  = 2'd2
	} reg_idx_t;

	typedef logic [DIG_W-1:0] digit_t;

	// effective configuration after clamping
	typedef struct packed {
		logic [DIMS_W-1:0] dims;
		logic [LEFF_W-1:0] side;
		logic              tri_en;
	} cfg_t;

	// classified site waiting for the back end
	typedef struct packed {
		logic [IDX_W-1:0]            idx;
		digit_t [MAX_DIMS-1:0]       dig;
		logic                        oor;
		logic                        neg;
	} entry_t;

	typedef struct packed {
		logic [IDX_W-1:0] word;
		digit_t           rem;
	} div_t;

	// restoring division, STG_BITS quotient bits per call
	function automatic div_t div_step(input logic [IDX_W-1:0] word, input digit_t rem,
					  input logic [LEFF_W-1:0] dvs);
		logic [IDX_W-1:0]  w;
		logic [LEFF_W-1:0] r;
		div_t              res;
		w = word;
		r = {1'b0, rem};
		for (int b = 0; b < STG_BITS; b++) begin
			r = {r[DIG_W-1:0], w[IDX_W-1]};
			w = {w[IDX_W-2:0], 1'b0};
			if (r >= dvs) begin
				r    = r - dvs;
				w[0] = 1'b1;
			end
		end
		res.word = w;
		res.rem  = r[DIG_W-1:0];
		return res;
	endfunction

endpackage

`default_nettype wire

FILE: hdl/plng_if.sv
`default_nettype none

// site index channel
interface plng_site_if;
	logic                         valid;
	logic                         ready;
	logic [plng_pkg::IDX_W-1:0]   site_index;

	modport source (output valid, output site_index, input ready);
	modport sink (input valid, input site_index, output ready);
endinterface

// neighbour result channel
interface plng_nbr_if;
	logic                         valid;
	logic                         ready;
	logic [plng_pkg::IDX_W-1:0]   neighbor_index;
	logic [plng_pkg::AXIS_W-1:0]  axis;
	logic                         step_up;
	logic                         diagonal;
	logic                         sign_negative;
	logic                         out_of_range;
	logic                         last;

	modport source (output valid, output neighbor_index, output axis, output step_up,
			output diagonal, output sign_negative, output out_of_range, output last,
			input ready);
	modport sink (input valid, input neighbor_index, input axis, input step_up,
		      input diagonal, input sign_negative, input out_of_range, input last,
		      output ready);
endinterface

`default_nettype wire

FILE: hdl/plng_front.sv
`default_nettype none

module plng_front (
	input  logic                clk,
	input  logic                arst_n,
	plng_site_if.sink           sites,
	input  plng_pkg::cfg_t      cfg,
	input  logic                q_full,
	output logic                push,
	output plng_pkg::entry_t    push_entry
);

	typedef struct packed {
		logic [plng_pkg::IDX_W-1:0]              idx;
		logic [plng_pkg::IDX_W-1:0]              word;
		plng_pkg::digit_t                        rem;
		plng_pkg::digit_t [plng_pkg::MAX_DIMS-1:0] dig;
		logic [plng_pkg::MAX_DIMS-1:0]           qnz;
	} stg_t;

	logic [plng_pkg::NSTG-1:0] vld_s;
	stg_t                      stg_s [plng_pkg::NSTG];
	stg_t                      nxt [plng_pkg::NSTG];
	logic                      en;
	stg_t                      tail;
	logic                      neg;

	// whole pipeline moves unless the finished site cannot enter the queue
	assign en          = !vld_s[plng_pkg::NSTG-1] || !q_full;
	assign sites.ready = en;
	assign push        = vld_s[plng_pkg::NSTG-1] && !q_full;

	// one slice of the coordinate divider per stage
	always_comb begin
		stg_t            cur;
		plng_pkg::div_t  dr;
		for (int s = 0; s < plng_pkg::NSTG; s++) begin
			if (s == 0) begin
				cur.idx  = sites.site_index;
				cur.word = sites.site_index;
				cur.rem  = '0;
				cur.dig  = '0;
				cur.qnz  = '0;
			end else begin
				cur = stg_s[s-1];
			end
			dr          = plng_pkg::div_step(cur.word, cur.rem, cfg.side);
			nxt[s]      = cur;
			nxt[s].word = dr.word;
			nxt[s].rem  = dr.rem;
			// end of one coordinate: keep the remainder, restart on the quotient
			if ((s % plng_pkg::STG_PER_DIV) == plng_pkg::STG_PER_DIV - 1) begin
				nxt[s].dig[s / plng_pkg::STG_PER_DIV] = dr.rem;
				nxt[s].qnz[s / plng_pkg::STG_PER_DIV] = (dr.word != '0);
				nxt[s].rem                            = '0;
			end
		end
	end

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[plng_pkg::NSTG-2:0], sites.valid};
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (en) begin
			for (int s = 0; s < plng_pkg::NSTG; s++) begin
				stg_s[s] <= nxt[s];
			end
		end
	end

	// classify: range from the quotient after the last used coordinate, parity of even digits
	assign tail = stg_s[plng_pkg::NSTG-1];

	always_comb begin
		neg = 1'b0;
		for (int j = 0; j < plng_pkg::MAX_DIMS; j++) begin
			if (j < int'(cfg.dims)) begin
				neg = neg ^ ~tail.dig[j][0];
			end
		end
	end

	assign push_entry.idx = tail.idx;
	assign push_entry.dig = tail.dig;
	assign push_entry.oor = tail.qnz[cfg.dims - 2'd1];
	assign push_entry.neg = neg;

endmodule

`default_nettype wire

FILE: hdl/plng_queue.sv
`default_nettype none

module plng_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  plng_pkg::entry_t    push_entry,
	output logic                full,
	input  logic                pop,
	output logic                head_valid,
	output plng_pkg::entry_t    head
);

	plng_pkg::entry_t            mem_q [plng_pkg::QDEPTH];
	logic [plng_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [plng_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [plng_pkg::QPTR_W:0]   cnt_q;

	assign full       = (cnt_q == (plng_pkg::QPTR_W+1)'(plng_pkg::QDEPTH));
	assign head_valid = (cnt_q != '0);
	assign head       = mem_q[rd_ptr_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule

`default_nettype wire

FILE: hdl/plng_back.sv
`default_nettype none

module plng_back (
	input  logic                clk,
	input  logic                arst_n,
	input  plng_pkg::cfg_t      cfg,
	input  logic                head_valid,
	input  plng_pkg::entry_t    head,
	output logic                pop,
	plng_nbr_if.source          nbrs
);

	logic [plng_pkg::POW_W-1:0]      pw_q [plng_pkg::MAX_DIMS+1];
	logic [plng_pkg::POW_W-1:0]      wrap_q [plng_pkg::MAX_DIMS];
	logic [plng_pkg::CNT_W-1:0]      k_q;

	logic                            out_vld_q;
	logic [plng_pkg::IDX_W-1:0]      nb_q;
	logic [plng_pkg::AXIS_W-1:0]     axis_q;
	logic                            up_q;
	logic                            diag_q;
	logic                            neg_q;
	logic                            oor_q;
	logic                            last_q;

	logic                            tri2;
	logic [plng_pkg::CNT_W-1:0]      cnt;
	logic [plng_pkg::CNT_W-1:0]      two_d;
	logic                            is_last;
	logic                            is_diag;
	logic                            up;
	logic [plng_pkg::AXIS_W-1:0]     ax;
	logic [plng_pkg::POW_IDX_W-1:0]  ja;
	logic signed [plng_pkg::ACC_W-1:0] ta;
	logic signed [plng_pkg::ACC_W-1:0] tb;
	logic signed [plng_pkg::ACC_W-1:0] sum;
	logic                            load;

	// signed offset from the site to one neighbour along one digit
	function automatic logic signed [plng_pkg::ACC_W-1:0] nb_delta(
		input plng_pkg::digit_t             c,
		input logic                         dir_up,
		input logic [plng_pkg::LEFF_W-1:0]  side,
		input logic [plng_pkg::POW_W-1:0]   pw,
		input logic [plng_pkg::POW_W-1:0]   wrap
	);
		logic                              at_lo;
		logic                              at_hi;
		logic signed [plng_pkg::ACC_W-1:0] sp;
		logic signed [plng_pkg::ACC_W-1:0] sw;
		logic signed [plng_pkg::ACC_W-1:0] res;
		at_lo = (c == '0);
		at_hi = ({1'b0, c} == side - plng_pkg::LEFF_W'(1));
		sp    = $signed({1'b0, pw});
		sw    = $signed({1'b0, wrap});
		if (!dir_up) begin
			res = at_lo ? sw : -sp;
		end else begin
			res = at_hi ? -sw : sp;
		end
		return res;
	endfunction

	// powers of the side length and the wrap distances, rebuilt every cycle
	always_ff @(posedge clk) begin
		pw_q[0] <= plng_pkg::POW_W'(1);
		for (int i = 1; i <= plng_pkg::MAX_DIMS; i++) begin
			pw_q[i] <= plng_pkg::POW_W'(pw_q[i-1] * plng_pkg::POW_W'(cfg.side));
		end
		for (int i = 0; i < plng_pkg::MAX_DIMS; i++) begin
			wrap_q[i] <= pw_q[i+1] - pw_q[i];
		end
	end

	// result sequencing for the site at the queue head
	assign tri2    = cfg.tri_en && (cfg.dims == plng_pkg::DIMS_W'(2));
	assign two_d   = plng_pkg::CNT_W'({cfg.dims, 1'b0});
	assign cnt     = head.oor ? plng_pkg::CNT_W'(1)
			       : two_d + (tri2 ? plng_pkg::CNT_W'(2) : plng_pkg::CNT_W'(0));
	assign is_last = (k_q == cnt - plng_pkg::CNT_W'(1));
	assign is_diag = !head.oor && (k_q >= two_d);
	assign up      = k_q[0];
	assign ax      = plng_pkg::AXIS_W'(k_q >> 1);

	// axis n uses the digit of weight side^(dims-1-n); diagonals use both plane digits
	assign ja = is_diag ? plng_pkg::POW_IDX_W'(1)
			    : plng_pkg::POW_IDX_W'(cfg.dims - ax - plng_pkg::DIMS_W'(1));

	assign ta  = nb_delta(head.dig[ja], up, cfg.side, pw_q[ja], wrap_q[ja]);
	assign tb  = is_diag ? nb_delta(head.dig[0], up, cfg.side, pw_q[0], wrap_q[0]) : '0;
	assign sum = $signed({2'b00, head.idx}) + ta + tb;

	// output register decouples the sequencer from the sink
	assign load = head_valid && (!out_vld_q || nbrs.ready);
	assign pop  = load && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			k_q       <= '0;
		end else begin
			if (load) begin
				out_vld_q <= 1'b1;
				k_q       <= is_last ? '0 : k_q + 1'b1;
			end else if (nbrs.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			nb_q   <= head.oor ? '0 : sum[plng_pkg::IDX_W-1:0];
			axis_q <= (head.oor || is_diag) ? '0 : ax;
			up_q   <= !head.oor && up;
			diag_q <= is_diag;
			neg_q  <= !head.oor && head.neg;
			oor_q  <= head.oor;
			last_q <= is_last;
		end
	end

	assign nbrs.valid          = out_vld_q;
	assign nbrs.neighbor_index = nb_q;
	assign nbrs.axis           = axis_q;
	assign nbrs.step_up        = up_q;
	assign nbrs.diagonal       = diag_q;
	assign nbrs.sign_negative  = neg_q;
	assign nbrs.out_of_range   = oor_q;
	assign nbrs.last           = last_q;

endmodule

`default_nettype wire

FILE: hdl/periodic_lattice_neighbor_gen.sv
// path: a site passes 9 divider stages, the first loaded at the transfer, then the queue
//   and the output register before its first result is shown; later results of the same
//   site follow one per cycle while the receiver is ready
// flow: the divider takes a site every cycle unless a full queue holds the pipeline; the
//   sequencer gives 2*dims results per site, +2 if triangular, 1 if out of range (1 to 6)
// reset: asynchronous, clears all handshake and queue state and loads num_dims 2,
//   side_length 4, triangular_mode 0; no clearing pass, sites are taken right after reset
`default_nettype none

module periodic_lattice_neighbor_gen (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [plng_pkg::REG_IDX_W-1:0] cfg_index,
	input  logic [plng_pkg::CFG_W-1:0]     cfg_wdata,
	plng_site_if.sink                      sites,
	plng_nbr_if.source                     nbrs
);

	logic [plng_pkg::DIMS_W-1:0] dims_q;
	logic [plng_pkg::SIDE_W-1:0] side_q;
	logic                        tri_q;
	plng_pkg::cfg_t              cfg_eff;

	logic                        q_push;
	plng_pkg::entry_t            q_push_entry;
	logic                        q_full;
	logic                        q_pop;
	logic                        q_head_valid;
	plng_pkg::entry_t            q_head;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dims_q <= plng_pkg::DIMS_W'(2);
			side_q <= plng_pkg::SIDE_W'(4);
			tri_q  <= 1'b0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				plng_pkg::REG_NUM_DIMS: begin
					dims_q <= cfg_wdata[plng_pkg::DIMS_W-1:0];
				end
				plng_pkg::REG_SIDE_LENGTH: begin
					side_q <= cfg_wdata[plng_pkg::SIDE_W-1:0];
				end
				plng_pkg::REG_TRIANGULAR: begin
					tri_q <= cfg_wdata[0];
				end
				default: begin
				end
			endcase
		end
	end

	// clamp to the supported lattice
	always_comb begin
		if (dims_q == '0) begin
			cfg_eff.dims = plng_pkg::DIMS_W'(1);
		end else if (dims_q > plng_pkg::DIMS_W'(plng_pkg::MAX_DIMS)) begin
			cfg_eff.dims = plng_pkg::DIMS_W'(plng_pkg::MAX_DIMS);
		end else begin
			cfg_eff.dims = dims_q;
		end
		if (side_q == '0) begin
			cfg_eff.side = plng_pkg::LEFF_W'(1);
		end else if (side_q > plng_pkg::SIDE_W'(plng_pkg::MAX_SIDE)) begin
			cfg_eff.side = plng_pkg::LEFF_W'(plng_pkg::MAX_SIDE);
		end else begin
			cfg_eff.side = plng_pkg::LEFF_W'(side_q);
		end
		cfg_eff.tri_en = tri_q;
	end

	// coordinate split and range check
	plng_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.sites      (sites),
		.cfg        (cfg_eff),
		.q_full     (q_full),
		.push       (q_push),
		.push_entry (q_push_entry)
	);

	// classified sites between front and back
	plng_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_push_entry),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_head_valid),
		.head       (q_head)
	);

	// neighbour generation
	plng_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_eff),
		.head_valid (q_head_valid),
		.head       (q_head),
		.pop        (q_pop),
		.nbrs       (nbrs)
	);

	// checks
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("queue written while full");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_head_valid)
		else $error("queue read while empty");

	a_oor_single: assert property (@(posedge clk) disable iff (!arst_n)
		(nbrs.valid && nbrs.out_of_range) |->
			(nbrs.last && (nbrs.neighbor_index == '0) && !nbrs.diagonal))
		else $error("out-of-range result is not a single cleared result");

endmodule

`default_nettype wire

FILE: tb/periodic_lattice_neighbor_gen_tb.sv
`default_nettype none

module periodic_lattice_neighbor_gen_tb;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int STALL_CYCLES = 400;

	// one neighbour result as it leaves the block
	typedef struct packed {
		logic [plng_pkg::IDX_W-1:0]  neighbor_index;
		logic [plng_pkg::AXIS_W-1:0] axis;
		logic                        step_up;
		logic                        diagonal;
		logic                        sign_negative;
		logic                        out_of_range;
		logic                        last;
	} nbr_t;

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_wr_en;
	logic [plng_pkg::REG_IDX_W-1:0] cfg_index;
	logic [plng_pkg::CFG_W-1:0]     cfg_wdata;

	plng_site_if site_ch ();
	plng_nbr_if  nbr_ch ();

	periodic_lattice_neighbor_gen i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.sites     (site_ch),
		.nbrs      (nbr_ch)
	);

	// lattice settings as last written
	logic [plng_pkg::DIMS_W-1:0] lat_dims;
	logic [plng_pkg::SIDE_W-1:0] lat_side;
	logic                        lat_tri;

	nbr_t expected_nbrs [$];

	int  tx_idle_pct;
	int  rx_idle_pct;
	logic rx_hold;
	event rx_stall_go;
	int  error_count;
	int  sites_sent;
	int  results_checked;
	int  oor_sites;
	int  settings_used;
	int  cycle_count;

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				 expected_nbrs.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic report_error(input string msg);
		$display("ERROR at %0t: %s", $time, msg);
		error_count++;
	endtask

	function automatic void push_nbr(input longint unsigned nb, input int axis,
					 input bit up, input bit diag, input bit neg,
					 input bit oor, input bit last);
		nbr_t r;
		r.neighbor_index = nb[plng_pkg::IDX_W-1:0];
		r.axis           = axis[plng_pkg::AXIS_W-1:0];
		r.step_up        = up;
		r.diagonal       = diag;
		r.sign_negative  = neg;
		r.out_of_range   = oor;
		r.last           = last;
		expected_nbrs.insert(expected_nbrs.size(), r);
	endfunction

	// neighbours of one site under the current lattice settings
	function automatic void predict_neighbours(input logic [plng_pkg::IDX_W-1:0] idx);
		int              d;
		int              side;
		int              count;
		int              k;
		longint unsigned span;
		longint unsigned rest;
		longint unsigned base;
		longint unsigned lo;
		longint unsigned hi;
		longint unsigned lo_sum;
		longint unsigned hi_sum;
		longint unsigned stride [plng_pkg::MAX_DIMS];
		longint unsigned coord [plng_pkg::MAX_DIMS];
		bit              neg;
		bit              tri_on;
		d    = (lat_dims == 0) ? 1 : ((lat_dims > plng_pkg::MAX_DIMS) ? plng_pkg::MAX_DIMS
										: int'(lat_dims));
		side = (lat_side == 0) ? 1 : ((lat_side > plng_pkg::MAX_SIDE) ? plng_pkg::MAX_SIDE
										: int'(lat_side));
		span = 1;
		for (int n = d - 1; n >= 0; n--) begin
			stride[n] = span;
			span      = span * side;
		end
		if (idx >= span) begin
			push_nbr(0, 0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1);
			oor_sites++;
			return;
		end
		// split into coordinates, last one least significant
		rest = idx;
		neg  = 1'b0;
		for (int n = d - 1; n >= 0; n--) begin
			coord[n] = rest % side;
			rest     = rest / side;
			if (coord[n] % 2 == 0)
				neg = ~neg;
		end
		tri_on = (d == 2) && lat_tri;
		count  = 2 * d + (tri_on ? 2 : 0);
		k      = 0;
		lo_sum = 0;
		hi_sum = 0;
		for (int n = 0; n < d; n++) begin
			lo   = (coord[n] > 0) ? coord[n] - 1 : side - 1;
			hi   = (coord[n] < side - 1) ? coord[n] + 1 : 0;
			base = idx - coord[n] * stride[n];
			push_nbr(base + lo * stride[n], n, 1'b0, 1'b0, neg, 1'b0, k + 1 == count);
			k++;
			push_nbr(base + hi * stride[n], n, 1'b1, 1'b0, neg, 1'b0, k + 1 == count);
			k++;
			lo_sum += lo * stride[n];
			hi_sum += hi * stride[n];
		end
		// diagonal neighbours of the triangular plane
		if (tri_on) begin
			push_nbr(lo_sum, 0, 1'b0, 1'b1, neg, 1'b0, 1'b0);
			push_nbr(hi_sum, 0, 1'b1, 1'b1, neg, 1'b0, 1'b1);
		end
	endfunction

	task automatic check_field(input string name, input int unsigned got,
				   input int unsigned want);
		if (got !== want)
			report_error($sformatf("result %0d: %s is 0x%0h, expected 0x%0h",
					       results_checked, name, got, want));
	endtask

	task automatic check_nbr(input nbr_t got);
		nbr_t want;
		if (expected_nbrs.size() == 0) begin
			report_error($sformatf("unexpected result, neighbour 0x%0h",
					       got.neighbor_index));
			return;
		end
		want = expected_nbrs.pop_front();
		check_field("neighbor_index", got.neighbor_index, want.neighbor_index);
		check_field("axis", got.axis, want.axis);
		check_field("step_up", got.step_up, want.step_up);
		check_field("diagonal", got.diagonal, want.diagonal);
		check_field("sign_negative", got.sign_negative, want.sign_negative);
		check_field("out_of_range", got.out_of_range, want.out_of_range);
		check_field("last", got.last, want.last);
		results_checked++;
	endtask

	// result side: check each transfer and drive ready
	always @(posedge clk) begin
		if (arst_n && nbr_ch.valid && nbr_ch.ready)
			check_nbr({nbr_ch.neighbor_index, nbr_ch.axis, nbr_ch.step_up,
				   nbr_ch.diagonal, nbr_ch.sign_negative, nbr_ch.out_of_range,
				   nbr_ch.last});
		nbr_ch.ready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
	end

	// long receiver hold-off, counted here
	initial begin
		rx_hold = 1'b0;
		forever begin
			@(rx_stall_go);
			rx_hold <= 1'b1;
			repeat (STALL_CYCLES) @(posedge clk);
			rx_hold <= 1'b0;
		end
	end

	// offer one site and wait for its transfer
	task automatic send_site(input logic [plng_pkg::IDX_W-1:0] idx);
		while ($urandom_range(99) < tx_idle_pct) begin
			site_ch.valid <= 1'b0;
			@(posedge clk);
		end
		site_ch.valid      <= 1'b1;
		site_ch.site_index <= idx;
		do
			@(posedge clk);
		while (!site_ch.ready);
		predict_neighbours(idx);
		sites_sent++;
	endtask

	// drop valid and wait until every expected result has come
	task automatic wait_until_drained();
		site_ch.valid <= 1'b0;
		while (expected_nbrs.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input plng_pkg::reg_idx_t idx,
				 input logic [plng_pkg::CFG_W-1:0] value);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic set_lattice(input logic [plng_pkg::CFG_W-1:0] dims,
				   input logic [plng_pkg::CFG_W-1:0] side,
				   input logic [plng_pkg::CFG_W-1:0] tri_val);
		wait_until_drained();
		write_reg(plng_pkg::REG_NUM_DIMS, dims);
		write_reg(plng_pkg::REG_SIDE_LENGTH, side);
		write_reg(plng_pkg::REG_TRIANGULAR, tri_val);
		lat_dims = dims[plng_pkg::DIMS_W-1:0];
		lat_side = side[plng_pkg::SIDE_W-1:0];
		lat_tri  = tri_val[0];
		settings_used++;
	endtask

	// mostly in range, some just past the end, some anywhere
	function automatic logic [plng_pkg::IDX_W-1:0] pick_site();
		int              d;
		int              side;
		int              r;
		longint unsigned span;
		d    = (lat_dims == 0) ? 1 : int'(lat_dims);
		side = (lat_side == 0) ? 1 : ((lat_side > plng_pkg::MAX_SIDE) ? plng_pkg::MAX_SIDE
										: int'(lat_side));
		span = 1;
		repeat (d) span = span * side;
		r = $urandom_range(99);
		if (r < 78 || span >= (64'd1 << plng_pkg::IDX_W))
			return plng_pkg::IDX_W'($urandom_range(int'(span - 1), 0));
		else if (r < 88)
			return plng_pkg::IDX_W'(span + $urandom_range(3));
		else
			return plng_pkg::IDX_W'($urandom);
	endfunction

	// extremes, every special case, small and clamped lattices
	task automatic test_directed_cases();
		tx_idle_pct = 12;
		rx_idle_pct = 83;
		// settings after reset
		send_site(0);
		send_site(5);
		send_site(15);
		send_site(16);
		send_site(24'hFFFFFF);
		set_lattice(2, 4, 1);
		send_site(0);
		send_site(15);
		send_site(6);
		// side of one
		set_lattice(1, 1, 0);
		send_site(0);
		send_site(1);
		// triangular bit ignored off the plane, side of two
		set_lattice(3, 2, 1);
		send_site(0);
		send_site(7);
		send_site(8);
		// zero dims and zero side count as one
		set_lattice(0, 0, 1);
		send_site(0);
		send_site(1);
		// oversized side clamped
		set_lattice(3, 511, 0);
		send_site(0);
		send_site(24'hFFFFFF);
		send_site(24'h800000);
		set_lattice(2, 256, 1);
		send_site(24'h00FFFF);
		send_site(24'h010000);
		send_site(0);
		set_lattice(1, 256, 1);
		send_site(255);
		send_site(256);
	endtask

	// random settings and sites under one idling pattern
	task automatic test_random_traffic(input int tx_pct, input int rx_pct);
		int r;
		int side;
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		repeat (4) begin
			r = $urandom_range(99);
			if (r < 60)
				side = $urandom_range(8, 1);
			else if (r < 80)
				side = $urandom_range(40, 9);
			else if (r < 90)
				side = plng_pkg::MAX_SIDE;
			else if (r < 95)
				side = 0;
			else
				side = $urandom_range(511, 257);
			// unused upper bits of the narrow registers are set at random
			set_lattice({7'($urandom), 2'($urandom_range(3))},
				    side[plng_pkg::CFG_W-1:0], 9'($urandom));
			repeat (18) send_site(pick_site());
		end
	endtask

	// receiver holds off while sites keep coming, so the input stalls
	task automatic test_output_backpressure();
		set_lattice(3, 5, 0);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		-> rx_stall_go;
		repeat (24) send_site(pick_site());
	endtask

	initial begin
		arst_n             = 1'b0;
		cfg_wr_en          = 1'b0;
		cfg_index          = plng_pkg::REG_NUM_DIMS;
		cfg_wdata          = '0;
		site_ch.valid      = 1'b0;
		site_ch.site_index = '0;
		lat_dims           = 2'd2;
		lat_side           = 9'd4;
		lat_tri            = 1'b0;
		tx_idle_pct        = 0;
		rx_idle_pct        = 0;
		error_count        = 0;
		sites_sent         = 0;
		results_checked    = 0;
		oor_sites          = 0;
		settings_used      = 1;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		test_random_traffic(12, 83);
		test_random_traffic(83, 12);
		test_random_traffic(0, 0);
		test_output_backpressure();
		wait_until_drained();
		// room for any stray result to show up
		repeat (30) @(posedge clk);

		$display("%0d sites sent under %0d lattice settings, %0d out of range",
			 sites_sent, settings_used, oor_sites);
		$display("%0d neighbour results checked, %0d mismatches", results_checked,
			 error_count);
		if (error_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

`default_nettype wire

FILE: sim.f
hdl/plng_pkg.sv
hdl/plng_if.sv
hdl/plng_front.sv
hdl/plng_queue.sv
hdl/plng_back.sv
hdl/periodic_lattice_neighbor_gen.sv
tb/periodic_lattice_neighbor_gen_tb.sv
